// ===== hw/rtl/blti_pkg.sv =====
// shared types, constants and helpers of the bilinear table interpolator
`default_nettype none
package blti_pkg;

  // value and table geometry
  localparam int unsigned VW = 32;   // value width, signed q16.16
  localparam int unsigned PW = 4;    // breakpoint position width
  localparam int unsigned NP = 16;   // breakpoints per axis
  localparam int unsigned GW = 8;    // grid address width
  localparam int unsigned CW = 5;    // count register width
  localparam int unsigned WW = 33;   // interval weight width
  localparam int unsigned AW = 104;  // product accumulator width
  localparam int unsigned DW = 67;   // divisor / remainder width
  localparam int unsigned BW = 6;    // multiplier bit counter width
  localparam int unsigned QW = 7;    // divider step counter width

  // request kinds
  localparam logic [1:0] REQ_AX1   = 2'd0;
  localparam logic [1:0] REQ_AX2   = 2'd1;
  localparam logic [1:0] REQ_GRID  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // configuration register indexes
  localparam logic CFG_AX1_CNT = 1'b0;
  localparam logic CFG_AX2_CNT = 1'b1;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [PW-1:0]        row_pos;
    logic [PW-1:0]        col_pos;
    logic signed [VW-1:0] write_data;
    logic signed [VW-1:0] query_x;
    logic signed [VW-1:0] query_y;
  } req_t;

  typedef struct packed {
    logic signed [VW-1:0] interp_value;
    logic [1:0]           status;
  } rsp_t;

  // queue entry: request plus its class
  typedef struct packed {
    logic is_query;
    req_t req;
  } item_t;

  // breakpoints in use, clamped to the table size
  function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] c);
    return (c > CW'(NP)) ? CW'(NP) : c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/blti_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module blti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/blti_front.sv =====
// front end: accepts request words, tags queries and queues every word
`default_nettype none
module blti_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  blti_pkg::req_t   in_data_i,
  output logic             deq_valid_o,
  input  logic             deq_ready_i,
  output blti_pkg::item_t  deq_item_o
);

  blti_pkg::item_t ent_q [2];
  logic            wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign deq_valid_o = (cnt_q != 2'd0);
  assign deq_item_o  = ent_q[rptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = deq_valid_o & deq_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // classify and store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q].is_query <= (in_data_i.req_type == blti_pkg::REQ_QUERY);
      ent_q[wptr_q].req      <= in_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/blti_back.sv =====
// back end: table storage, interval search, serial multiply and divide
`default_nettype none
module blti_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       deq_valid_i,
  output logic                       deq_ready_o,
  input  blti_pkg::item_t            deq_item_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [blti_pkg::CW-1:0]    cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output blti_pkg::rsp_t             out_data_o
);

  localparam int unsigned VW = blti_pkg::VW;
  localparam int unsigned PW = blti_pkg::PW;
  localparam int unsigned GW = blti_pkg::GW;
  localparam int unsigned CW = blti_pkg::CW;
  localparam int unsigned WW = blti_pkg::WW;
  localparam int unsigned AW = blti_pkg::AW;
  localparam int unsigned DW = blti_pkg::DW;
  localparam int unsigned BW = blti_pkg::BW;
  localparam int unsigned QW = blti_pkg::QW;

  // product sequence of the shared multiplier
  localparam logic [2:0] OP_V00 = 3'd0;
  localparam logic [2:0] OP_V01 = 3'd1;
  localparam logic [2:0] OP_V10 = 3'd2;
  localparam logic [2:0] OP_V11 = 3'd3;
  localparam logic [2:0] OP_T0  = 3'd4;
  localparam logic [2:0] OP_T1  = 3'd5;
  localparam logic [2:0] OP_DEN = 3'd6;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRD   = 9'b000000010,
    S_SCMP  = 9'b000000100,
    S_FETCH = 9'b000001000,
    S_WGT   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_RND   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CW-1:0] na, nb, last;
  logic          out_valid_q, out_valid_d;
  blti_pkg::rsp_t out_q, out_d;

  logic signed [VW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [PW-1:0] ka_q, ka_d, kb_q, kb_d, idx_q, idx_d;
  logic [2:0]    fcnt_q, fcnt_d;
  logic signed [VW-1:0] x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic signed [VW-1:0] v_q [4];
  logic signed [VW-1:0] v_d [4];
  logic signed [WW-1:0] wx1_q, wx1_d, wx0_q, wx0_d, wy1_q, wy1_d, wy0_q, wy0_d;
  logic signed [WW-1:0] wxd_q, wxd_d, wyd_q, wyd_d;
  logic [2:0]    op_q, op_d;
  logic [BW-1:0] bit_q, bit_d;
  logic signed [AW-1:0] ash_q, ash_d, acc_q, acc_d, t0_q, t0_d, t1_q, t1_d;
  logic signed [AW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d, denm_q, denm_d;
  logic [AW-1:0] qd_q, qd_d;
  logic          neg_q, neg_d;
  logic [QW-1:0] dcnt_q, dcnt_d;
  logic signed [VW-1:0] res_q, res_d;
  logic [1:0]    stat_q, stat_d;

  // ram ports
  logic          ax1_we, ax2_we, grid_we;
  logic [PW-1:0] ax1_ra, ax2_ra;
  logic [GW-1:0] grid_ra;
  logic [VW-1:0] ax1_rd, ax2_rd, grid_rd;
  logic          wr_pop;

  // combinational helpers
  logic signed [WW-1:0] bsel;
  logic signed [AW-1:0] term, acc_n, aload, numm, denabs;
  logic [DW:0]          rem_sh, rem_sub;
  logic                 ge, rnd;
  logic [AW-1:0]        qr;
  logic [WW-1:0]        lim, mag;
  logic signed [WW-1:0] qxe, qye, x0e, x1e, y0e, y1e;

  assign na   = blti_pkg::clamp_cnt(cnt1_q);
  assign nb   = blti_pkg::clamp_cnt(cnt2_q);
  assign last = ((na > nb) ? na : nb) - CW'(2);

  // table writes happen as the write word leaves the queue
  assign deq_ready_o = (state_q == S_IDLE);
  assign wr_pop      = deq_valid_i & deq_ready_o & ~deq_item_i.is_query;
  assign ax1_we  = wr_pop & (deq_item_i.req.req_type == blti_pkg::REQ_AX1);
  assign ax2_we  = wr_pop & (deq_item_i.req.req_type == blti_pkg::REQ_AX2);
  assign grid_we = wr_pop & (deq_item_i.req.req_type == blti_pkg::REQ_GRID);

  // read addresses for search and fetch
  always_comb begin
    ax1_ra  = idx_q;
    ax2_ra  = idx_q;
    grid_ra = {ka_q, kb_q};
    if (state_q == S_FETCH) begin
      case (fcnt_q)
        3'd0: begin
          ax1_ra  = ka_q;
          ax2_ra  = kb_q;
          grid_ra = {ka_q, kb_q};
        end
        3'd1: begin
          ax1_ra  = ka_q + PW'(1);
          ax2_ra  = kb_q + PW'(1);
          grid_ra = {ka_q, kb_q + PW'(1)};
        end
        3'd2: grid_ra = {ka_q + PW'(1), kb_q};
        default: grid_ra = {ka_q + PW'(1), kb_q + PW'(1)};
      endcase
    end
  end

  blti_ram #(.WIDTH(VW), .DEPTH(blti_pkg::NP)) u_ax1_ram (
    .clk_i   (clk_i),
    .we_i    (ax1_we),
    .waddr_i (deq_item_i.req.row_pos),
    .wdata_i (deq_item_i.req.write_data),
    .raddr_i (ax1_ra),
    .rdata_o (ax1_rd)
  );

  blti_ram #(.WIDTH(VW), .DEPTH(blti_pkg::NP)) u_ax2_ram (
    .clk_i   (clk_i),
    .we_i    (ax2_we),
    .waddr_i (deq_item_i.req.col_pos),
    .wdata_i (deq_item_i.req.write_data),
    .raddr_i (ax2_ra),
    .rdata_o (ax2_rd)
  );

  blti_ram #(.WIDTH(VW), .DEPTH(blti_pkg::NP * blti_pkg::NP)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i ({deq_item_i.req.row_pos, deq_item_i.req.col_pos}),
    .wdata_i (deq_item_i.req.write_data),
    .raddr_i (grid_ra),
    .rdata_o (grid_rd)
  );

  // sign extended coordinates for the weights
  assign qxe = {qx_q[VW-1], qx_q};
  assign qye = {qy_q[VW-1], qy_q};
  assign x0e = {x0_q[VW-1], x0_q};
  assign x1e = {x1_q[VW-1], x1_q};
  assign y0e = {y0_q[VW-1], y0_q};
  assign y1e = {y1_q[VW-1], y1_q};

  // multiplier operand selection
  always_comb begin
    case (op_q)
      OP_V00, OP_V10: bsel = wy1_q;
      OP_V01, OP_V11: bsel = wy0_q;
      OP_T0:          bsel = wx1_q;
      OP_T1:          bsel = wx0_q;
      default:        bsel = wyd_q;
    endcase
    case (op_q + 3'd1)
      OP_V01:  aload = {{(AW-VW){v_q[1][VW-1]}}, v_q[1]};
      OP_V10:  aload = {{(AW-VW){v_q[2][VW-1]}}, v_q[2]};
      OP_V11:  aload = {{(AW-VW){v_q[3][VW-1]}}, v_q[3]};
      OP_T0:   aload = t0_q;
      OP_T1:   aload = t1_q;
      default: aload = {{(AW-WW){wxd_q[WW-1]}}, wxd_q};
    endcase
    term  = bsel[bit_q] ? ash_q : '0;
    acc_n = (bit_q == BW'(WW - 1)) ? (acc_q - term) : (acc_q + term);
    numm   = num_q[AW-1] ? -num_q : num_q;
    denabs = acc_n[AW-1] ? -acc_n : acc_n;
  end

  // divider step, final rounding and saturation
  always_comb begin
    rem_sh  = {rem_q, qd_q[AW-1]};
    ge      = (rem_sh >= {1'b0, denm_q});
    rem_sub = rem_sh - {1'b0, denm_q};
    rnd     = ({rem_q, 1'b0} >= {1'b0, denm_q});
    qr      = qd_q + AW'(rnd);
    lim     = neg_q ? (WW'(1) << (VW - 1)) : ((WW'(1) << (VW - 1)) - WW'(1));
    mag     = (qr > AW'(lim)) ? lim : qr[WW-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt1_d = cnt1_q;
    cnt2_d = cnt2_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d = out_q;
    qx_d = qx_q;
    qy_d = qy_q;
    ka_d = ka_q;
    kb_d = kb_q;
    idx_d = idx_q;
    fcnt_d = fcnt_q;
    x0_d = x0_q;
    x1_d = x1_q;
    y0_d = y0_q;
    y1_d = y1_q;
    v_d = v_q;
    wx1_d = wx1_q;
    wx0_d = wx0_q;
    wy1_d = wy1_q;
    wy0_d = wy0_q;
    wxd_d = wxd_q;
    wyd_d = wyd_q;
    op_d = op_q;
    bit_d = bit_q;
    ash_d = ash_q;
    acc_d = acc_q;
    t0_d = t0_q;
    t1_d = t1_q;
    num_d = num_q;
    rem_d = rem_q;
    denm_d = denm_q;
    qd_d = qd_q;
    neg_d = neg_q;
    dcnt_d = dcnt_q;
    res_d = res_q;
    stat_d = stat_q;

    // count registers
    if (cfg_we_i) begin
      if (cfg_idx_i == blti_pkg::CFG_AX1_CNT) begin
        cnt1_d = cfg_wdata_i;
      end else begin
        cnt2_d = cfg_wdata_i;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (deq_valid_i && deq_item_i.is_query) begin
          qx_d = deq_item_i.req.query_x;
          qy_d = deq_item_i.req.query_y;
          ka_d = '0;
          kb_d = '0;
          idx_d = PW'(1);
          fcnt_d = '0;
          if (na < CW'(2) || nb < CW'(2)) begin
            res_d = '0;
            stat_d = blti_pkg::ST_DEGEN;
            state_d = S_DONE;
          end else if (last == '0) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        if (CW'(idx_q) <= na - CW'(2) && $signed(ax1_rd) <= qx_q) begin
          ka_d = idx_q;
        end
        if (CW'(idx_q) <= nb - CW'(2) && $signed(ax2_rd) <= qy_q) begin
          kb_d = idx_q;
        end
        if (CW'(idx_q) == last) begin
          state_d = S_FETCH;
        end else begin
          idx_d = idx_q + PW'(1);
          state_d = S_SRD;
        end
      end
      S_FETCH: begin
        fcnt_d = fcnt_q + 3'd1;
        case (fcnt_q)
          3'd1: begin
            x0_d = ax1_rd;
            y0_d = ax2_rd;
            v_d[0] = grid_rd;
          end
          3'd2: begin
            x1_d = ax1_rd;
            y1_d = ax2_rd;
            v_d[1] = grid_rd;
          end
          3'd3: v_d[2] = grid_rd;
          3'd4: begin
            v_d[3] = grid_rd;
            state_d = S_WGT;
          end
          default: ;
        endcase
      end
      S_WGT: begin
        wx1_d = x1e - qxe;
        wx0_d = qxe - x0e;
        wy1_d = y1e - qye;
        wy0_d = qye - y0e;
        wxd_d = x1e - x0e;
        wyd_d = y1e - y0e;
        op_d = OP_V00;
        bit_d = '0;
        acc_d = '0;
        ash_d = {{(AW-VW){v_q[0][VW-1]}}, v_q[0]};
        if (x1_q == x0_q || y1_q == y0_q) begin
          res_d = '0;
          stat_d = blti_pkg::ST_DEGEN;
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        ash_d = ash_q <<< 1;
        bit_d = bit_q + BW'(1);
        acc_d = acc_n;
        if (bit_q == BW'(WW - 1)) begin
          bit_d = '0;
          op_d = op_q + 3'd1;
          ash_d = aload;
          case (op_q)
            OP_V01: begin
              t0_d = acc_n;
              acc_d = '0;
            end
            OP_V11: begin
              t1_d = acc_n;
              acc_d = '0;
            end
            OP_T1: begin
              num_d = acc_n;
              acc_d = '0;
            end
            OP_DEN: begin
              qd_d = numm;
              denm_d = denabs[DW-1:0];
              neg_d = num_q[AW-1] ^ acc_n[AW-1];
              rem_d = '0;
              dcnt_d = '0;
              state_d = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        qd_d = {qd_q[AW-2:0], ge};
        dcnt_d = dcnt_q + QW'(1);
        if (dcnt_q == QW'(AW - 1)) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        res_d = neg_q ? VW'(WW'(0) - mag) : mag[VW-1:0];
        stat_d = (qr > AW'(lim)) ? blti_pkg::ST_SAT : blti_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_d.interp_value = res_q;
          out_d.status = stat_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt1_q <= CW'(2);
      cnt2_q <= CW'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt1_q <= cnt1_d;
      cnt2_q <= cnt2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    qx_q <= qx_d;
    qy_q <= qy_d;
    ka_q <= ka_d;
    kb_q <= kb_d;
    idx_q <= idx_d;
    fcnt_q <= fcnt_d;
    x0_q <= x0_d;
    x1_q <= x1_d;
    y0_q <= y0_d;
    y1_q <= y1_d;
    v_q <= v_d;
    wx1_q <= wx1_d;
    wx0_q <= wx0_d;
    wy1_q <= wy1_d;
    wy0_q <= wy0_d;
    wxd_q <= wxd_d;
    wyd_q <= wyd_d;
    op_q <= op_d;
    bit_q <= bit_d;
    ash_q <= ash_d;
    acc_q <= acc_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    num_q <= num_d;
    rem_q <= rem_d;
    denm_q <= denm_d;
    qd_q <= qd_d;
    neg_q <= neg_d;
    dcnt_q <= dcnt_d;
    res_q <= res_d;
    stat_q <= stat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bilinear_table_interpolator_unit.sv =====
// Two-axis lookup table with bilinear interpolation in signed q16.16.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries words that write an
// axis breakpoint, write a grid value, or ask a query; only queries produce an
// output word on out_valid_o/out_ready_i/out_data_o, in arrival order.
// The count registers are set through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must set them only while idle, which the block itself does not enforce.
// A two-entry queue sits between the input and the execution engine, so words
// are taken while a result waits on the output register.
// A table write is done as its word leaves the queue. A query leaves the queue,
// then runs the breakpoint search, the table fetch and weight setup, the
// bit-serial multiplier (six weighted terms and the cell area), the bit-serial
// divider and rounding, and loads the output register; one query is in
// execution at a time.
// Reset empties the queue, drops any pending result and sets both counts to 2;
// table contents are undefined until written.
// When the receiver stalls, the finished result holds on the output and the
// engine waits, while the queue keeps taking words until full.
`default_nettype none
module bilinear_table_interpolator_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  blti_pkg::req_t          in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output blti_pkg::rsp_t          out_data_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [blti_pkg::CW-1:0] cfg_wdata_i
);

  logic            deq_valid, deq_ready;
  blti_pkg::item_t deq_item;

  // accept and queue words
  blti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_item_o  (deq_item)
  );

  // execute writes and queries
  blti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .deq_item_i  (deq_item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
